[hw/rtl/txrp_pkg.sv]
// Shared types and constants of the transmit ring packetizer.
package txrp_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int PACKET_MAX_DEF = 64;

  // Fixed field widths
  localparam int LEN_W   = 7;
  localparam int COUNT_W = 12;
  localparam int BYTE_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam logic [LEN_W-1:0]   CFG_RESET = 7'd64;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Per-request summary handed from front to back
  typedef struct packed {
    logic               stored;
    logic [COUNT_W-1:0] accepted;
    logic [LEN_W-1:0]   plen;
  } job_t;

endpackage

[hw/rtl/txrp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module txrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/txrp_front.sv]
// Front end: accepts requests, updates ring pointers and decides packet starts.
module txrp_front import txrp_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PACKET_MAX = PACKET_MAX_DEF,
  localparam int AW = $clog2(RING_DEPTH),
  localparam int SW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_of_write,
  input  logic              link_accepts,
  input  logic              back_busy,
  input  logic              q_ready,
  output logic              q_push,
  output job_t              q_job,
  output logic [AW-1:0]     q_start,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata
);

  logic [LEN_W-1:0]   max_packet_bytes;
  logic [AW-1:0]      write_position;
  logic [AW-1:0]      read_position;
  logic               link_busy;
  logic [LEN_W-1:0]   pending_bytes;
  logic [COUNT_W-1:0] write_count;

  logic               accept;
  logic               is_write;
  logic [LEN_W-1:0]   lim;
  logic [AW-1:0]      wp_inc;
  logic               store;
  logic [COUNT_W-1:0] wcount_inc;
  logic [SW-1:0]      rp_sum;
  logic [AW-1:0]      rp_adv;
  logic [AW-1:0]      rp_eff;
  logic [AW-1:0]      wp_eff;
  logic               busy_eff;
  logic               try_send;
  logic [SW-1:0]      run;
  logic [LEN_W-1:0]   len;
  logic               start;

  // Hold a completion until the back end has read out the previous packet
  assign in_ready = q_ready && !(kind == KIND_DONE && back_busy);
  assign accept   = in_valid && in_ready;
  assign is_write = (kind == KIND_WRITE);

  // Clamp the packet limit to 1..PACKET_MAX
  always_comb begin
    lim = max_packet_bytes;
    if (max_packet_bytes == '0) begin
      lim = LEN_W'(1);
    end else if (32'(max_packet_bytes) > PACKET_MAX) begin
      lim = LEN_W'(PACKET_MAX);
    end
  end

  // Store path, one slot kept empty
  assign wp_inc     = (write_position == AW'(RING_DEPTH - 1)) ? '0 : write_position + AW'(1);
  assign store      = is_write && (wp_inc != read_position);
  assign wcount_inc = (store && write_count != COUNT_SAT) ? write_count + COUNT_W'(1)
                                                          : write_count;

  // Free the pending bytes on completion
  assign rp_sum = SW'(read_position) + SW'(pending_bytes);
  assign rp_adv = (rp_sum == SW'(RING_DEPTH)) ? '0 : rp_sum[AW-1:0];

  assign rp_eff   = is_write ? read_position : rp_adv;
  assign wp_eff   = store ? wp_inc : write_position;
  assign busy_eff = is_write ? link_busy : 1'b0;
  assign try_send = is_write ? last_of_write : 1'b1;

  // Contiguous run from tail, capped at the limit
  assign run   = (wp_eff > rp_eff) ? SW'(wp_eff) - SW'(rp_eff)
                                   : SW'(RING_DEPTH) - SW'(rp_eff);
  assign len   = (run > SW'(lim)) ? lim : LEN_W'(run);
  assign start = try_send && !busy_eff && (wp_eff != rp_eff) && link_accepts;

  // Hand the request summary to the back end
  assign q_push         = accept;
  assign q_job.stored   = store;
  assign q_job.accepted = is_write ? wcount_inc : '0;
  assign q_job.plen     = start ? len : '0;
  assign q_start        = rp_eff;

  assign ram_we    = accept && store;
  assign ram_waddr = write_position;
  assign ram_wdata = data_byte;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_bytes <= CFG_RESET;
    end else if (cfg_valid) begin
      max_packet_bytes <= cfg_data;
    end
  end

  // Advance ring state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      read_position  <= '0;
      link_busy      <= 1'b0;
      pending_bytes  <= '0;
      write_count    <= '0;
    end else if (accept) begin
      write_position <= wp_eff;
      read_position  <= rp_eff;
      link_busy      <= start ? 1'b1 : busy_eff;
      if (start) begin
        pending_bytes <= len;
      end else if (!is_write) begin
        pending_bytes <= '0;
      end
      if (is_write) begin
        write_count <= last_of_write ? '0 : wcount_inc;
      end
    end
  end

endmodule

[hw/rtl/txrp_queue.sv]
// Two-entry queue of request summaries between front and back end.
module txrp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty
);

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = (count != (PW + 1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

endmodule

[hw/rtl/txrp_back.sv]
// Back end: turns request summaries into results, reading packet bytes from the ring.
module txrp_back import txrp_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  job_t               q_job,
  input  logic [AW-1:0]      q_start,
  output logic               q_pop,
  output logic               busy,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [BYTE_W-1:0]  ram_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               byte_stored,
  output logic [COUNT_W-1:0] accepted_in_write,
  output logic               packet_started,
  output logic               has_packet_byte,
  output logic [BYTE_W-1:0]  packet_byte,
  output logic [LEN_W-1:0]   packet_length,
  output logic               last_result
);

  logic [LEN_W-1:0] remain;
  logic [AW-1:0]    addr;
  logic             out_free;
  logic             cont;

  assign out_free = !out_valid || out_ready;
  assign cont     = (remain != '0) && out_free;
  assign q_pop    = (remain == '0) && out_free && q_valid;
  assign busy     = q_valid || (remain != '0);

  // Issue one ring read per packet byte
  assign ram_re    = cont || (q_pop && q_job.plen != '0);
  assign ram_raddr = cont ? addr : q_start;

  assign packet_started = has_packet_byte;
  assign packet_byte    = has_packet_byte ? ram_rdata : '0;

  // Output valid and byte countdown
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remain    <= '0;
    end else if (cont) begin
      out_valid <= 1'b1;
      remain    <= remain - LEN_W'(1);
    end else if (q_pop) begin
      out_valid <= 1'b1;
      remain    <= (q_job.plen == '0) ? '0 : q_job.plen - LEN_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields and read address
  always_ff @(posedge clk) begin
    if (cont) begin
      addr        <= addr + AW'(1);
      last_result <= (remain == LEN_W'(1));
    end else if (q_pop) begin
      addr              <= q_start + AW'(1);
      byte_stored       <= q_job.stored;
      accepted_in_write <= q_job.accepted;
      packet_length     <= q_job.plen;
      has_packet_byte   <= (q_job.plen != '0);
      last_result       <= (q_job.plen <= LEN_W'(1));
    end
  end

endmodule

[hw/rtl/tx_ring_packetizer.sv]
// Top level of the transmit byte ring packetizer.
//
// Requests enter on in_valid/in_ready: a write of one byte (kind 0) or a
// link completion (kind 1). Results leave on out_valid/out_ready: one
// result per request, or one per packet byte when the request started a
// packet. The one configuration register, the packet size limit, is written
// on cfg_valid/cfg_ready, which is always ready.
// A request's summary passes through the queue and then the output register
// before its result is valid.
// Throughput, while the receiver takes results: one request per cycle;
// packet bytes stream at one per cycle, set by the single read port of
// the ring memory. A completion request is held off until the back end
// is idle: queue empty and every byte of the previous packet read out.
// A two-entry queue sits between request handling and result output.
// Reset clears the pointers, counters and link state and sets the limit to
// 64; ring contents are not cleared and no clearing pass runs.
// When the receiver stalls, the output register holds, the queue fills and
// then in_ready drops.
module tx_ring_packetizer import txrp_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PACKET_MAX = PACKET_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               last_of_write,
  input  logic               link_accepts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               byte_stored,
  output logic [COUNT_W-1:0] accepted_in_write,
  output logic               packet_started,
  output logic               has_packet_byte,
  output logic [BYTE_W-1:0]  packet_byte,
  output logic [LEN_W-1:0]   packet_length,
  output logic               last_result
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int QW = $bits(job_t) + AW;

  logic              back_busy;
  logic              q_ready;
  logic              q_push;
  job_t              f_job;
  logic [AW-1:0]     f_start;
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_dout;
  job_t              b_job;
  logic [AW-1:0]     b_start;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  txrp_front #(
    .RING_DEPTH (RING_DEPTH),
    .PACKET_MAX (PACKET_MAX)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .last_of_write (last_of_write),
    .link_accepts  (link_accepts),
    .back_busy     (back_busy),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_job         (f_job),
    .q_start       (f_start),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  txrp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       ({f_start, f_job}),
    .not_full  (q_ready),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_valid)
  );

  assign b_job   = q_dout[$bits(job_t)-1:0];
  assign b_start = q_dout[QW-1:$bits(job_t)];

  txrp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  txrp_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_job             (b_job),
    .q_start           (b_start),
    .q_pop             (q_pop),
    .busy              (back_busy),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .byte_stored       (byte_stored),
    .accepted_in_write (accepted_in_write),
    .packet_started    (packet_started),
    .has_packet_byte   (has_packet_byte),
    .packet_byte       (packet_byte),
    .packet_length     (packet_length),
    .last_result       (last_result)
  );

endmodule

[hw/rtl/txrp_checker.sv]
// Port-level checker for the transmit ring packetizer, bound to the top level.
module txrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       packet_started,
  input logic       has_packet_byte,
  input logic [7:0] packet_byte,
  input logic [6:0] packet_length,
  input logic       last_result
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Drop output valid after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Packet byte results carry a started packet of nonzero length
  a_pkt_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_packet_byte |-> packet_started && packet_length != 7'd0)
    else $error("packet byte without a started packet");

  // A result without a packet byte is the only and last one of its request
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_packet_byte |->
      last_result && !packet_started && packet_length == 7'd0 && packet_byte == 8'd0)
    else $error("malformed single result");

endmodule

bind tx_ring_packetizer txrp_checker u_txrp_checker (.*);

[dv/tx_ring_packetizer_tb.sv]
// Self-checking testbench for the transmit ring packetizer, with its own predictor.
`timescale 1ns / 100ps

module tx_ring_packetizer_tb;
  import txrp_pkg::*;

  // One predicted result of a request
  typedef struct {
    logic               stored;
    logic [COUNT_W-1:0] accepted;
    logic               started;
    logic               has_byte;
    logic [BYTE_W-1:0]  pbyte;
    logic [LEN_W-1:0]   plen;
    logic               last;
  } emit_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic [BYTE_W-1:0]  data_byte;
  logic               last_of_write;
  logic               link_accepts;
  logic               out_valid;
  logic               out_ready;
  logic               byte_stored;
  logic [COUNT_W-1:0] accepted_in_write;
  logic               packet_started;
  logic               has_packet_byte;
  logic [BYTE_W-1:0]  packet_byte;
  logic [LEN_W-1:0]   packet_length;
  logic               last_result;

  // Shadow copy of the ring and its pointers
  logic [BYTE_W-1:0]  sh_ring [RING_DEPTH_DEF];
  int                 sh_head;
  int                 sh_tail;
  logic               sh_busy;
  int                 sh_inflight;
  logic [COUNT_W-1:0] sh_wcount;
  logic [LEN_W-1:0]   sh_limit;

  emit_t emit_q[$];
  emit_t got_e;

  int err_count      = 0;
  int n_requests     = 0;
  int n_results      = 0;
  int n_packets      = 0;
  int n_drops        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tx_ring_packetizer dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .data_byte         (data_byte),
    .last_of_write     (last_of_write),
    .link_accepts      (link_accepts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .byte_stored       (byte_stored),
    .accepted_in_write (accepted_in_write),
    .packet_started    (packet_started),
    .has_packet_byte   (has_packet_byte),
    .packet_byte       (packet_byte),
    .packet_length     (packet_length),
    .last_result       (last_result)
  );

  // Try to start a packet from the tail; returns its length, 0 if none
  function automatic int try_packet(input logic acc);
    int len;
    int lim;
    if (sh_busy || sh_head == sh_tail) return 0;
    len = (sh_head > sh_tail) ? sh_head - sh_tail : RING_DEPTH_DEF - sh_tail;
    lim = (sh_limit == 0) ? 1 : ((sh_limit > PACKET_MAX_DEF) ? PACKET_MAX_DEF : sh_limit);
    if (len > lim) len = lim;
    if (!acc) return 0;
    sh_inflight = len;
    sh_busy     = 1'b1;
    return len;
  endfunction

  // Advance the shadow ring by one request and queue its results
  task automatic predict_request(input logic k, input logic [BYTE_W-1:0] d,
                                 input logic lw, input logic acc);
    emit_t e;
    int    nxt;
    int    plen;
    e.stored   = 1'b0;
    e.accepted = '0;
    e.started  = 1'b0;
    e.has_byte = 1'b0;
    e.pbyte    = '0;
    e.plen     = '0;
    e.last     = 1'b1;
    plen       = 0;
    if (k == KIND_WRITE) begin
      nxt = (sh_head + 1) % RING_DEPTH_DEF;
      if (nxt != sh_tail) begin
        sh_ring[sh_head] = d;
        sh_head          = nxt;
        e.stored         = 1'b1;
        if (sh_wcount != COUNT_SAT) sh_wcount = sh_wcount + 1'b1;
      end else begin
        n_drops++;
      end
      e.accepted = sh_wcount;
      if (lw) begin
        plen      = try_packet(acc);
        sh_wcount = '0;
      end
    end else begin
      // free the bytes of the finished packet first
      sh_tail     = (sh_tail + sh_inflight) % RING_DEPTH_DEF;
      sh_inflight = 0;
      sh_busy     = 1'b0;
      plen        = try_packet(acc);
    end
    if (plen == 0) begin
      emit_q.push_back(e);
    end else begin
      n_packets++;
      for (int i = 0; i < plen; i++) begin
        e.started  = 1'b1;
        e.has_byte = 1'b1;
        e.pbyte    = sh_ring[(sh_tail + i) % RING_DEPTH_DEF];
        e.plen     = LEN_W'(plen);
        e.last     = (i == plen - 1);
        emit_q.push_back(e);
      end
    end
  endtask

  // Offer one request, hold it until accepted; returns at a falling edge
  task automatic send_request(input logic k, input logic [BYTE_W-1:0] d,
                              input logic lw, input logic acc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    data_byte     <= d;
    last_of_write <= lw;
    link_accepts  <= acc;
    do @(posedge clk); while (!in_ready);
    n_requests++;
    predict_request(k, d, lw, acc);
    @(negedge clk);
  endtask

  // Send one write call of nbytes bytes, last flag on the final byte
  task automatic send_write_burst(input int nbytes, input logic acc);
    for (int i = 0; i < nbytes; i++)
      send_request(KIND_WRITE, BYTE_W'($urandom_range(255)), i == nbytes - 1, acc);
  endtask

  // Complete packets until the ring is empty and the link idle
  task automatic flush_ring();
    while (sh_busy || sh_head != sh_tail)
      send_request(KIND_DONE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  // Stop offering and wait for every queued result
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (emit_q.size() != 0) @(negedge clk);
  endtask

  // Write the packet size limit while the block is idle
  task automatic write_limit(input logic [LEN_W-1:0] v);
    settle();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sh_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (emit_q.size() == 0) begin
        $error("result with no request waiting for it");
        err_count++;
      end else begin
        got_e = emit_q.pop_front();
        n_results++;
        check_field("byte_stored", got_e.stored, byte_stored);
        check_field("accepted_in_write", got_e.accepted, accepted_in_write);
        check_field("packet_started", got_e.started, packet_started);
        check_field("has_packet_byte", got_e.has_byte, has_packet_byte);
        check_field("packet_byte", got_e.pbyte, packet_byte);
        check_field("packet_length", got_e.plen, packet_length);
        check_field("last_result", got_e.last, last_result);
      end
    end
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Refusal, busy link, spurious complete, byte extremes, count reset
  task automatic test_directed_basics();
    send_request(KIND_WRITE, 8'h00, 1'b1, 1'b0);
    send_request(KIND_WRITE, 8'hFF, 1'b1, 1'b1);
    send_request(KIND_WRITE, 8'hA5, 1'b1, 1'b1);
    send_request(KIND_DONE,  8'h3C, 1'b1, 1'b0);
    send_request(KIND_DONE,  8'hFF, 1'b0, 1'b1);
    send_request(KIND_DONE,  8'h00, 1'b0, 1'b1);
    send_request(KIND_DONE,  8'h5A, 1'b1, 1'b1);
    send_request(KIND_WRITE, 8'h01, 1'b0, 1'b0);
    send_request(KIND_WRITE, 8'h80, 1'b0, 1'b1);
    send_request(KIND_WRITE, 8'h7F, 1'b0, 1'b0);
    send_request(KIND_WRITE, 8'hFE, 1'b0, 1'b1);
    send_request(KIND_WRITE, 8'h55, 1'b1, 1'b1);
    send_request(KIND_DONE,  8'hAA, 1'b0, 1'b0);
    // a complete in the middle of a write keeps the running count
    send_request(KIND_WRITE, 8'h55, 1'b0, 1'b1);
    send_request(KIND_DONE,  8'h11, 1'b0, 1'b1);
    send_request(KIND_WRITE, 8'hAA, 1'b1, 1'b1);
    send_request(KIND_DONE,  8'h22, 1'b1, 1'b1);
    send_request(KIND_DONE,  8'h33, 1'b0, 1'b1);
    settle();
  endtask

  // Limit of zero, one, above the maximum, seven, and back to the reset value;
  // the long write under the largest limit is cut at the packet maximum
  task automatic test_packet_limits();
    logic [LEN_W-1:0] lims [6];
    int               bursts [6];
    lims   = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd7, CFG_RESET};
    bursts = '{4, 4, 66, 10, 10, 10};
    for (int i = 0; i < 6; i++) begin
      write_limit(lims[i]);
      send_write_burst(bursts[i], 1'b1);
      flush_ring();
    end
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_limit(CFG_RESET);
    hold_left = 300;
    send_write_burst(20, 1'b1);
    send_request(KIND_DONE, BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
    send_write_burst(6, 1'b1);
    flush_ring();
    settle();
  endtask

  // Mostly well-formed writes and completes, some noise, four idle mixes
  task automatic test_random_mix();
    int send_pcts [4];
    int recv_pcts [4];
    int n;
    int r;
    int len;
    send_pcts = '{0, 47, 0, 13};
    recv_pcts = '{0, 0, 47, 13};
    for (int p = 0; p < 4; p++) begin
      write_limit(LEN_W'($urandom_range(1, 64)));
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      n = 0;
      while (n < 16) begin
        r = $urandom_range(99);
        if (r < 65) begin
          len = ($urandom_range(19) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
          send_write_burst(len, $urandom_range(9) != 0);
          n += len;
        end else if (r < 88) begin
          send_request(KIND_DONE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                       $urandom_range(6) != 0);
          n++;
        end else begin
          // broken write: bytes with no closing last flag
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            send_request(KIND_WRITE, BYTE_W'($urandom_range(255)), 1'b0,
                         1'($urandom_range(1)));
          n += len;
        end
      end
      settle();
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = KIND_WRITE;
    data_byte     = '0;
    last_of_write = 1'b0;
    link_accepts  = 1'b0;
    out_ready     = 1'b0;
    sh_head       = 0;
    sh_tail       = 0;
    sh_busy       = 1'b0;
    sh_inflight   = 0;
    sh_wcount     = '0;
    sh_limit      = CFG_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_packet_limits();
    test_backpressure();
    test_random_mix();

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d packets, %0d bytes dropped",
             n_requests, n_results, n_packets, n_drops);
    $display("limits 0/1/7/64/65/127 and random, packet cap, receiver hold-off, idle mixes");
    if (err_count == 0) begin
      $display("tx_ring_packetizer_tb: done, clean");
    end else begin
      $display("tx_ring_packetizer_tb: done, errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("tx_ring_packetizer_tb: done, errors");
    $finish;
  end

endmodule
